// ----- sv/smm_pkg.sv -----
package smm_pkg;
	localparam int STRIPE = 8;
	localparam int INNER = 64;
	localparam int ROW_W = 3;
	localparam int KW = 6;
	localparam int ADDR_W = 9;
	localparam int ACC_W = 40;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	typedef enum logic [1:0] {
		CMD_LOAD_A = 2'd0,
		CMD_LOAD_B = 2'd1,
		CMD_LOAD_MAP = 2'd2,
		CMD_START = 2'd3
	} cmd_t;

	localparam logic REG_INNER_LEN = 1'b0;
	localparam logic REG_STRIPE_LEN = 1'b1;

	// One classified request: a store write or a start.
	typedef struct packed {
		logic start;
		logic wr_a;
		logic wr_b;
		logic wr_map;
		logic [ADDR_W-1:0] addr;
		logic [15:0] value;
		logic [11:0] gcol;
	} op_t;

	typedef struct packed {
		logic [ROW_W-1:0] out_row;
		logic [11:0] out_column;
		logic signed [ACC_W-1:0] product_value;
		logic last;
	} res_t;
endpackage

// ----- sv/smm_if.sv -----
interface smm_in_if;
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [5:0] first_index;
	logic [5:0] second_index;
	logic signed [15:0] element_value;
	logic [11:0] global_column;
	modport source(output valid, command, first_index, second_index, element_value,
		global_column, input ready);
	modport sink(input valid, command, first_index, second_index, element_value,
		global_column, output ready);
endinterface

interface smm_out_if;
	logic valid;
	logic ready;
	logic [2:0] out_row;
	logic [11:0] out_column;
	logic signed [39:0] product_value;
	logic last;
	modport source(output valid, out_row, out_column, product_value, last, input ready);
	modport sink(input valid, out_row, out_column, product_value, last, output ready);
endinterface

interface smm_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic [6:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- sv/smm_front.sv -----
module smm_front (
	input logic clk,
	input logic arst_n,
	smm_in_if.sink in_ch,
	output smm_pkg::op_t op,
	output logic op_valid,
	input logic op_ready
);
	import smm_pkg::*;

	op_t q_mem [QDEPTH];
	logic [QPTR_W:0] wr_q, rd_q;
	logic full, push, pop;
	op_t cls;

	assign full = (wr_q[QPTR_W] != rd_q[QPTR_W]) && (wr_q[QPTR_W-1:0] == rd_q[QPTR_W-1:0]);
	assign in_ch.ready = !full;
	assign push = in_ch.valid && !full;
	assign op_valid = wr_q != rd_q;
	assign pop = op_valid && op_ready;
	assign op = q_mem[rd_q[QPTR_W-1:0]];

	always_comb begin
		cls = '0;
		cls.value = in_ch.element_value;
		cls.gcol = in_ch.global_column;
		unique case (cmd_t'(in_ch.command))
			CMD_LOAD_A: begin
				cls.wr_a = (in_ch.first_index < 6'(STRIPE));
				cls.addr = {in_ch.first_index[ROW_W-1:0], in_ch.second_index};
			end
			CMD_LOAD_B: begin
				cls.wr_b = (in_ch.second_index < 6'(STRIPE));
				cls.addr = {in_ch.first_index, in_ch.second_index[ROW_W-1:0]};
			end
			CMD_LOAD_MAP: begin
				cls.wr_map = (in_ch.first_index < 6'(STRIPE));
				cls.addr = ADDR_W'(in_ch.first_index[ROW_W-1:0]);
			end
			CMD_START: cls.start = 1'b1;
			default: cls = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wr_q[QPTR_W-1:0]] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
		end
	end

	a_qcount: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_q - rd_q) <= (QPTR_W+1)'(QDEPTH)) else $error("queue count overrun");
	a_nopush_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push while full");
	a_popvalid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> op_valid) else $error("pop from empty queue");
endmodule

// ----- sv/smm_back.sv -----
module smm_back (
	input logic clk,
	input logic arst_n,
	input smm_pkg::op_t op,
	input logic op_valid,
	output logic op_ready,
	input logic [6:0] inner_len,
	input logic [3:0] stripe_len,
	output logic busy,
	smm_out_if.source out_ch
);
	import smm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	logic [15:0] a_mem [STRIPE*INNER];
	logic [15:0] b_mem [INNER*STRIPE];
	logic [11:0] map_q [STRIPE];

	state_t state_q;
	logic [6:0] kn;
	logic [3:0] sn;
	logic [ROW_W-1:0] r_q, c_q;
	logic [KW:0] k_q;
	logic [3:0] kn_cnt_q;
	logic [6:0] kn_q;
	logic [3:0] sn_q;
	logic [15:0] a_s1, b_s1;
	logic v_s1, v_s2;
	logic signed [31:0] p_s2;
	logic signed [ACC_W-1:0] acc_q;
	res_t res_q;
	logic out_v_q;
	logic last_k;

	assign kn = (inner_len > 7'(INNER)) ? 7'(INNER) : inner_len;
	assign sn = (stripe_len > 4'(STRIPE)) ? 4'(STRIPE) : stripe_len;
	assign op_ready = (state_q == ST_IDLE) && !(op.start && out_v_q);
	assign busy = state_q != ST_IDLE;
	assign last_k = (k_q + 1'b1) == (KW+1)'(kn_q);

	always_ff @(posedge clk) begin
		if (op_valid && op_ready) begin
			if (op.wr_a) a_mem[op.addr] <= op.value;
			if (op.wr_b) b_mem[op.addr] <= op.value;
			if (op.wr_map) map_q[op.addr[ROW_W-1:0]] <= op.gcol;
		end
		a_s1 <= a_mem[{r_q, k_q[KW-1:0]}];
		b_s1 <= b_mem[{k_q[KW-1:0], c_q}];
		p_s2 <= $signed(a_s1) * $signed(b_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q <= '0;
			c_q <= '0;
			k_q <= '0;
			kn_q <= '0;
			sn_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			acc_q <= '0;
			out_v_q <= 1'b0;
			res_q <= '0;
			kn_cnt_q <= '0;
		end else begin
			v_s1 <= (state_q == ST_RUN) && (kn_q != 7'd0);
			v_s2 <= v_s1;
			if (v_s2) acc_q <= acc_q + ACC_W'(p_s2);
			if (out_ch.valid && out_ch.ready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (op_valid && op_ready && op.start && sn != 4'd0) begin
						kn_q <= kn;
						sn_q <= sn;
						r_q <= '0;
						c_q <= '0;
						k_q <= '0;
						acc_q <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (kn_q == 7'd0 || last_k) begin
						state_q <= ST_DRAIN;
						kn_cnt_q <= 4'd2;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// Let the two pipeline stages finish into the accumulator.
					if (kn_cnt_q != 4'd0) kn_cnt_q <= kn_cnt_q - 1'b1;
					else if (!out_v_q) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					out_v_q <= 1'b1;
					res_q.out_row <= r_q;
					res_q.out_column <= map_q[c_q];
					res_q.product_value <= acc_q;
					res_q.last <= (4'(r_q) == sn_q - 1'b1) && (4'(c_q) == sn_q - 1'b1);
					acc_q <= '0;
					k_q <= '0;
					if (4'(c_q) == sn_q - 1'b1) begin
						c_q <= '0;
						if (4'(r_q) == sn_q - 1'b1) begin
							r_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							r_q <= r_q + 1'b1;
							state_q <= ST_RUN;
						end
					end else begin
						c_q <= c_q + 1'b1;
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.out_row = res_q.out_row;
	assign out_ch.out_column = res_q.out_column;
	assign out_ch.product_value = res_q.product_value;
	assign out_ch.last = res_q.last;

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> !out_v_q) else $error("result overwritten");
	a_no_mac_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !v_s1 || $past(state_q) == ST_RUN)
		else $error("stray multiply in idle");
endmodule

// ----- sv/striped_matrix_multiply_top.sv -----
// Load requests are accepted back to back through a four-entry queue while it has room.
// A start emits stripe_len^2 results, kn being inner_len capped at 64 and stripe_len capped
// at 8; each result takes kn multiply-accumulates, a drain and one emit.
// A result appears once its dot product has drained from the two-stage multiply pipeline.
// arst_n clears the queue, the sequencer and the registers (inner_len 64, stripe_len 8);
// the stores are not cleared and must be written before they are read.
module striped_matrix_multiply_top (
	input logic clk,
	input logic arst_n,
	smm_in_if.sink in_ch,
	smm_out_if.source out_ch,
	smm_cfg_if.sink cfg_ch
);
	import smm_pkg::*;

	op_t op;
	logic op_valid, op_ready, busy;
	logic [6:0] inner_len_q;
	logic [3:0] stripe_len_q;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_len_q <= 7'd64;
			stripe_len_q <= 4'd8;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_INNER_LEN: inner_len_q <= cfg_ch.data;
				REG_STRIPE_LEN: stripe_len_q <= cfg_ch.data[3:0];
				default: ;
			endcase
		end
	end

	smm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.op(op), .op_valid(op_valid), .op_ready(op_ready)
	);

	smm_back u_back (
		.clk(clk), .arst_n(arst_n), .op(op), .op_valid(op_valid), .op_ready(op_ready),
		.inner_len(inner_len_q), .stripe_len(stripe_len_q), .busy(busy), .out_ch(out_ch)
	);

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ch.valid |-> !busy) else $error("configuration written while busy");
endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import smm_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 8;

	logic clk;
	logic arst_n;

	smm_in_if in_ch ();
	smm_out_if out_ch ();
	smm_cfg_if cfg_ch ();

	striped_matrix_multiply_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	// Shadow of the block: stores, which entries hold data, and the registers.
	logic signed [15:0] a_image [STRIPE*INNER];
	logic signed [15:0] b_image [INNER*STRIPE];
	logic [11:0] col_image [STRIPE];
	bit a_set [STRIPE*INNER];
	bit b_set [INNER*STRIPE];
	bit col_set [STRIPE];
	logic [6:0] inner_reg;
	logic [3:0] stripe_reg;

	res_t expected_products [$];
	int err_count;
	int src_idle;
	int snk_stall;
	int hold_request;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input longint want, input longint got);
		$display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
		err_count++;
	endtask

	function automatic int eff_inner();
		return (inner_reg > INNER) ? INNER : int'(inner_reg);
	endfunction

	function automatic int eff_stripe();
		return (stripe_reg > STRIPE) ? STRIPE : int'(stripe_reg);
	endfunction

	// Works out every product element a start emits under the current settings.
	task automatic predict_products();
		int kn;
		int sn;
		longint acc;
		res_t r;
		kn = eff_inner();
		sn = eff_stripe();
		for (int row = 0; row < sn; row++) begin
			for (int col = 0; col < sn; col++) begin
				acc = 0;
				for (int k = 0; k < kn; k++)
					acc += longint'(a_image[row*INNER+k]) * longint'(b_image[k*STRIPE+col]);
				r.out_row = row[ROW_W-1:0];
				r.out_column = col_image[col];
				r.product_value = acc[ACC_W-1:0];
				r.last = (row == sn-1 && col == sn-1);
				expected_products.push_back(r);
			end
		end
	endtask

	task automatic apply_request(input cmd_t cmd, input int i1, input int i2,
		input logic [15:0] val, input logic [11:0] gcol);
		case (cmd)
			CMD_LOAD_A: begin
				if (i1 < STRIPE && i2 < INNER) begin
					a_image[i1*INNER+i2] = val;
					a_set[i1*INNER+i2] = 1'b1;
				end
			end
			CMD_LOAD_B: begin
				if (i1 < INNER && i2 < STRIPE) begin
					b_image[i1*STRIPE+i2] = val;
					b_set[i1*STRIPE+i2] = 1'b1;
				end
			end
			CMD_LOAD_MAP: begin
				if (i1 < STRIPE) begin
					col_image[i1] = gcol;
					col_set[i1] = 1'b1;
				end
			end
			default: predict_products();
		endcase
	endtask

	// Called at a rising edge; returns at the edge at which the request was taken,
	// leaving valid high so that the next request can follow without a gap.
	task automatic send_request(input cmd_t cmd, input int i1, input int i2,
		input logic [15:0] val, input logic [11:0] gcol);
		while ($urandom_range(99) < src_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.first_index <= i1[5:0];
		in_ch.second_index <= i2[5:0];
		in_ch.element_value <= val;
		in_ch.global_column <= gcol;
		do
			@(posedge clk);
		while (!in_ch.ready);
		apply_request(cmd, i1, i2, val, gcol);
	endtask

	task automatic drop_valid();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		drop_valid();
		wait (expected_products.size() == 0);
		@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [6:0] data);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		if (idx == REG_INNER_LEN)
			inner_reg = data;
		else
			stripe_reg = data[3:0];
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] random_q88();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'hffff;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	// Fills every store entry that a start under the current settings would read.
	task automatic load_missing();
		int kn;
		int sn;
		kn = eff_inner();
		sn = eff_stripe();
		for (int r = 0; r < sn; r++)
			for (int k = 0; k < kn; k++)
				if (!a_set[r*INNER+k])
					send_request(CMD_LOAD_A, r, k, random_q88(), 12'($urandom));
		for (int k = 0; k < kn; k++)
			for (int c = 0; c < sn; c++)
				if (!b_set[k*STRIPE+c])
					send_request(CMD_LOAD_B, k, c, random_q88(), 12'($urandom));
		for (int c = 0; c < sn; c++)
			if (!col_set[c])
				send_request(CMD_LOAD_MAP, c, $urandom_range(63), random_q88(),
					12'($urandom));
	endtask

	task automatic start_checked();
		load_missing();
		send_request(CMD_START, $urandom_range(63), $urandom_range(63), random_q88(),
			12'($urandom));
	endtask

	// Extreme operands, ignored loads and the degenerate settings.
	task automatic test_directed();
		write_reg(REG_INNER_LEN, 7'd1);
		write_reg(REG_STRIPE_LEN, 7'd1);
		send_request(CMD_LOAD_A, 0, 0, 16'h8000, 12'h000);
		send_request(CMD_LOAD_B, 0, 0, 16'h8000, 12'h000);
		send_request(CMD_LOAD_MAP, 0, 0, 16'h0000, 12'hfff);
		send_request(CMD_START, 63, 63, 16'hffff, 12'hfff);
		send_request(CMD_LOAD_B, 0, 0, 16'h7fff, 12'h000);
		send_request(CMD_START, 0, 0, 16'h0000, 12'h000);
		send_request(CMD_LOAD_A, 0, 0, 16'h7fff, 12'hfff);
		send_request(CMD_START, 0, 0, 16'h0000, 12'h000);
		// Out-of-range loads must leave the stores alone; an in-range map load follows them.
		send_request(CMD_LOAD_A, 8, 0, 16'h1234, 12'h000);
		send_request(CMD_LOAD_A, 63, 63, 16'h1234, 12'h000);
		send_request(CMD_LOAD_B, 0, 8, 16'h1234, 12'h000);
		send_request(CMD_LOAD_B, 63, 63, 16'h1234, 12'h000);
		send_request(CMD_LOAD_MAP, 8, 0, 16'h0000, 12'h123);
		send_request(CMD_LOAD_MAP, 63, 0, 16'h0000, 12'h123);
		send_request(CMD_LOAD_MAP, 0, 63, 16'hffff, 12'h000);
		send_request(CMD_START, 0, 0, 16'h0000, 12'h000);
		write_reg(REG_INNER_LEN, 7'd0);
		send_request(CMD_START, 0, 0, 16'h0000, 12'h000);
		write_reg(REG_INNER_LEN, 7'd1);
		write_reg(REG_STRIPE_LEN, 7'd0);
		send_request(CMD_START, 0, 0, 16'h0000, 12'h000);
		write_reg(REG_STRIPE_LEN, 7'd2);
		start_checked();
		wait_idle();
	endtask

	// Each register beyond its cap, with the other kept small so the loads stay few.
	task automatic test_full_size();
		write_reg(REG_INNER_LEN, 7'd127);
		write_reg(REG_STRIPE_LEN, 7'd1);
		start_checked();
		write_reg(REG_INNER_LEN, 7'd2);
		write_reg(REG_STRIPE_LEN, 7'd15);
		start_checked();
		wait_idle();
	endtask

	task automatic test_random(input int idle_pct, input int stall_pct, input int n_items);
		int sent;
		int pick;
		src_idle = idle_pct;
		snk_stall = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				write_reg(REG_INNER_LEN, 7'($urandom_range(8)));
				write_reg(REG_STRIPE_LEN, ($urandom_range(4) == 0) ?
					7'($urandom_range(15)) : 7'($urandom_range(4)));
			end
			for (int j = 0; j < 8; j++) begin
				pick = $urandom_range(99);
				if (pick < 30)
					send_request(CMD_LOAD_A, $urandom_range((pick < 3) ? 63 : STRIPE-1),
						$urandom_range(eff_inner() > 0 ? eff_inner()-1 : 0),
						random_q88(), 12'($urandom));
				else if (pick < 60)
					send_request(CMD_LOAD_B,
						$urandom_range((pick < 33) ? 63 : INNER-1),
						$urandom_range((pick < 36) ? 63 : STRIPE-1),
						random_q88(), 12'($urandom));
				else if (pick < 75)
					send_request(CMD_LOAD_MAP, $urandom_range((pick < 63) ? 63 : STRIPE-1),
						$urandom_range(63), random_q88(), 12'($urandom));
				else
					start_checked();
				sent++;
			end
		end
		wait_idle();
	endtask

	// The receiver holds off while requests keep coming, so the block backs up.
	task automatic test_backpressure();
		src_idle = 0;
		snk_stall = 0;
		write_reg(REG_INNER_LEN, 7'd2);
		write_reg(REG_STRIPE_LEN, 7'd2);
		load_missing();
		hold_request = 400;
		for (int j = 0; j < 8; j++) begin
			send_request(CMD_LOAD_A, $urandom_range(1), $urandom_range(1), random_q88(), 12'h0);
			start_checked();
		end
		wait_idle();
	endtask

	task automatic test_paused_sender();
		src_idle = 15;
		snk_stall = 15;
		for (int j = 0; j < 4; j++) begin
			send_request(CMD_LOAD_B, $urandom_range(1), $urandom_range(1), random_q88(), 12'h0);
			start_checked();
			drop_valid();
			wait (expected_products.size() == 0);
			@(posedge clk);
		end
		wait_idle();
	endtask

	// Receiver ready, stalled at random by snk_stall, with an occasional long hold-off on request.
	initial begin
		int n;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				n = hold_request;
				hold_request = 0;
				out_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ch.ready <= ($urandom_range(99) >= snk_stall);
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_products.size() == 0) begin
				$display("%0t unexpected result row %0d column %0d", $realtime,
					out_ch.out_row, out_ch.out_column);
				err_count++;
			end else begin
				want = expected_products.pop_front();
				if (out_ch.out_row !== want.out_row)
					report_mismatch("out_row", want.out_row, out_ch.out_row);
				if (out_ch.out_column !== want.out_column)
					report_mismatch("out_column", want.out_column, out_ch.out_column);
				if (out_ch.product_value !== want.product_value)
					report_mismatch("product_value", want.product_value,
						out_ch.product_value);
				if (out_ch.last !== want.last)
					report_mismatch("last", want.last, out_ch.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("tb: errors");
		$finish;
	end

	initial begin
		err_count = 0;
		src_idle = 0;
		snk_stall = 0;
		hold_request = 0;
		inner_reg = 7'd64;
		stripe_reg = 4'd8;
		for (int i = 0; i < STRIPE*INNER; i++) begin
			a_image[i] = '0;
			b_image[i] = '0;
			a_set[i] = 1'b0;
			b_set[i] = 1'b0;
		end
		for (int i = 0; i < STRIPE; i++) begin
			col_image[i] = '0;
			col_set[i] = 1'b0;
		end
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_LOAD_A;
		in_ch.first_index = '0;
		in_ch.second_index = '0;
		in_ch.element_value = '0;
		in_ch.global_column = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_INNER_LEN;
		cfg_ch.data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_size();
		test_random(0, 0, 16);
		test_random(75, 0, 16);
		test_random(0, 75, 16);
		test_random(15, 15, 16);
		test_backpressure();
		test_paused_sender();

		wait_idle();
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule
